### hdl/ucl_pkg.sv
// ----------------------------------------------------------------------------
// ucl_pkg
// Shared types and constants for the UART command line matcher.
// ----------------------------------------------------------------------------
package ucl_pkg;

  // line end and printable range
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

  // command word storage
  localparam int CMD_CHARS_MAX = 10;
  localparam int CMD_LOW_W     = 64;
  localparam int CMD_HIGH_W    = 16;
  localparam int CMD_LEN_W     = 4;

  localparam logic [CMD_LOW_W-1:0]  CMD_LOW_RST  = 64'h4554_5F45_5449_5257;
  localparam logic [CMD_HIGH_W-1:0] CMD_HIGH_RST = 16'h5453;
  localparam logic [CMD_LEN_W-1:0]  CMD_LEN_RST  = 4'd10;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CMD_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CMD_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CMD_LEN  = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_OVERLONG = 3'd3,
    EV_INVALID  = 3'd4,
    EV_BARE_CR  = 3'd5
  } ucl_event_t;

  typedef struct packed {
    logic prefix_matches;
    logic line_invalid;
    logic line_overflow;
    logic carriage_pending;
  } ucl_flags_t;

  localparam ucl_flags_t FLAGS_CLEAR = '{
    prefix_matches:   1'b1,
    line_invalid:     1'b0,
    line_overflow:    1'b0,
    carriage_pending: 1'b0
  };

  // packed so that command_accepted sits in bit 0
  typedef struct packed {
    logic       stray_byte;
    ucl_event_t line_event;
    logic       command_accepted;
  } ucl_result_t;

  localparam int RESULT_W = $bits(ucl_result_t);
  localparam int OUT_W    = 8;

endpackage

### hdl/uart_command_line_matcher_core.sv
// ----------------------------------------------------------------------------
// uart_command_line_matcher_core
// Recognizes a received text line equal to a configured command word.
// ----------------------------------------------------------------------------
// an accepted rx item has its result item registered and valid in the next cycle
// throughput: one item per cycle while results are taken, set by the single result register
// the input side stays ready while the result register is empty or being taken
// reset: synchronous active-low, clears line state and restores the command
// word to its default, no result pending afterwards
module uart_command_line_matcher_core #(
  parameter int LINE_CAPACITY     = 32,
  parameter int MAX_COMMAND_CHARS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: rx_byte[7:0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  // tdata: command_accepted[0], line_event[3:1], stray_byte[4], zero[7:5]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ucl_pkg::OUT_W-1:0]        out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ucl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ucl_pkg::CMD_LOW_W-1:0]    cfg_data
);
  import ucl_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [CMD_LOW_W-1:0]  cmd_low_r;
  logic [CMD_HIGH_W-1:0] cmd_high_r;
  logic [CMD_LEN_W-1:0]  cmd_len_r;
  logic [LEN_W-1:0]      line_length_r;
  logic [LEN_W-1:0]      line_length_nxt;
  ucl_flags_t            flags_r;
  ucl_flags_t            flags_nxt;
  ucl_result_t           result_nxt;
  ucl_result_t           result_r;
  logic                  out_valid_r;
  logic                  in_fire;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - RESULT_W)'(0), result_r};

  ucl_step #(
    .LINE_CAPACITY     (LINE_CAPACITY),
    .MAX_COMMAND_CHARS (MAX_COMMAND_CHARS),
    .LEN_W             (LEN_W)
  ) u_step (
    .rx_byte            (in_tdata),
    .line_length        (line_length_r),
    .flags              (flags_r),
    .command_low_bytes  (cmd_low_r),
    .command_high_bytes (cmd_high_r),
    .command_length     (cmd_len_r),
    .line_length_nxt    (line_length_nxt),
    .flags_nxt          (flags_nxt),
    .result             (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_low_r  <= CMD_LOW_RST;
      cmd_high_r <= CMD_HIGH_RST;
      cmd_len_r  <= CMD_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_CMD_LOW:  cmd_low_r  <= cfg_data;
        CFG_IDX_CMD_HIGH: cmd_high_r <= cfg_data[CMD_HIGH_W-1:0];
        CFG_IDX_CMD_LEN:  cmd_len_r  <= cfg_data[CMD_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= '0;
      flags_r       <= FLAGS_CLEAR;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        line_length_r <= line_length_nxt;
        flags_r       <= flags_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  a_accept_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.command_accepted |-> result_r.line_event == EV_ACCEPT)
    else $error("accepted flag without accept event");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tdata == CHAR_LF |=> line_length_r == '0 && flags_r == FLAGS_CLEAR)
    else $error("line state not cleared after lf");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(line_length_r) <= 32'(LINE_CAPACITY - 1))
    else $error("line length beyond capacity");

  a_ovf_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && flags_r.line_overflow && !flags_r.carriage_pending &&
    in_tdata != CHAR_LF && in_tdata != CHAR_CR |=> $stable(line_length_r))
    else $error("overlong line kept growing");

endmodule

### hdl/ucl_step.sv
// ----------------------------------------------------------------------------
// ucl_step
// Per-byte line tracking: next line state and the result for one rx byte.
// ----------------------------------------------------------------------------
module ucl_step #(
  parameter int LINE_CAPACITY     = 32,
  parameter int MAX_COMMAND_CHARS = 10,
  parameter int LEN_W             = $clog2(LINE_CAPACITY)
) (
  input  logic [7:0]                       rx_byte,
  input  logic [LEN_W-1:0]                 line_length,
  input  ucl_pkg::ucl_flags_t              flags,
  input  logic [ucl_pkg::CMD_LOW_W-1:0]    command_low_bytes,
  input  logic [ucl_pkg::CMD_HIGH_W-1:0]   command_high_bytes,
  input  logic [ucl_pkg::CMD_LEN_W-1:0]    command_length,
  output logic [LEN_W-1:0]                 line_length_nxt,
  output ucl_pkg::ucl_flags_t              flags_nxt,
  output ucl_pkg::ucl_result_t             result
);
  import ucl_pkg::*;

  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

  logic [CMD_LOW_W+CMD_HIGH_W-1:0] cmd_chars;
  logic                            active;
  ucl_event_t                      drop_lf;
  ucl_event_t                      drop_cr;
  logic                            len_ok;
  logic                            accept_ok;
  logic [LEN_W-1:0]                base_len;
  ucl_flags_t                      base_flags;
  logic                            base_active;
  logic                            printable;
  logic [7:0]                      cmd_char;
  logic                            in_cmd;

  assign cmd_chars = {command_high_bytes, command_low_bytes};
  assign active    = (line_length != '0) || flags.line_invalid || flags.line_overflow;
  assign printable = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);

  always_comb begin
    if (!active) begin
      drop_lf = EV_NONE;
      drop_cr = EV_NONE;
    end else if (flags.line_overflow) begin
      drop_lf = EV_OVERLONG;
      drop_cr = EV_OVERLONG;
    end else if (flags.line_invalid) begin
      drop_lf = EV_INVALID;
      drop_cr = EV_INVALID;
    end else begin
      drop_lf = EV_MISMATCH;
      drop_cr = EV_BARE_CR;
    end
  end

  assign len_ok = (command_length != '0) &&
                  (32'(command_length) <= 32'(MAX_COMMAND_CHARS)) &&
                  (32'(line_length) == 32'(command_length));
  assign accept_ok = !flags.line_invalid && !flags.line_overflow &&
                     flags.prefix_matches && len_ok;

  // line state after a pending carriage return drops the line
  assign base_len    = flags.carriage_pending ? '0 : line_length;
  assign base_flags  = flags.carriage_pending ? FLAGS_CLEAR : flags;
  assign base_active = (base_len != '0) || base_flags.line_invalid ||
                       base_flags.line_overflow;

  // command character at the current position
  always_comb begin
    cmd_char = '0;
    in_cmd   = 1'b0;
    for (int i = 0; i < MAX_COMMAND_CHARS; i++) begin
      if (32'(base_len) == 32'(i)) begin
        cmd_char = cmd_chars[8*i +: 8];
        in_cmd   = 1'b1;
      end
    end
  end

  always_comb begin
    line_length_nxt = line_length;
    flags_nxt       = flags;
    result          = '{stray_byte: 1'b0, line_event: EV_NONE, command_accepted: 1'b0};
    if (rx_byte == CHAR_LF) begin
      result.command_accepted = accept_ok;
      result.line_event       = accept_ok ? EV_ACCEPT : drop_lf;
      line_length_nxt         = '0;
      flags_nxt               = FLAGS_CLEAR;
    end else if (rx_byte == CHAR_CR) begin
      if (flags.carriage_pending) begin
        result.line_event = drop_cr;
        line_length_nxt   = '0;
        flags_nxt         = FLAGS_CLEAR;
      end
      flags_nxt.carriage_pending = 1'b1;
    end else begin
      result.line_event = flags.carriage_pending ? drop_cr : EV_NONE;
      line_length_nxt   = base_len;
      flags_nxt         = base_flags;
      if (!printable) begin
        if (!base_active) begin
          result.stray_byte = 1'b1;
        end else begin
          flags_nxt.line_invalid = 1'b1;
        end
      end else if (!base_flags.line_invalid && !base_flags.line_overflow) begin
        if (base_len == LEN_LAST) begin
          flags_nxt.line_overflow = 1'b1;
        end else begin
          if (in_cmd && (32'(base_len) < 32'(command_length)) && (rx_byte != cmd_char)) begin
            flags_nxt.prefix_matches = 1'b0;
          end
          line_length_nxt = base_len + 1'b1;
        end
      end
    end
  end

endmodule

### tb/uart_command_line_matcher_core_tb.sv
// ----------------------------------------------------------------------------
// uart_command_line_matcher_core_tb
// Streams received bytes into the matcher and checks every result item
// against a cycle-free line predictor kept in the bench. Covers directed
// line endings, stray and control bytes, then random command lines, near
// misses, overlong and broken lines under several command words and
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_command_line_matcher_core_tb;
  import ucl_pkg::*;

  localparam int LINE_CAP = 32;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CMD_LOW_W-1:0] cfg_data = '0;

  uart_command_line_matcher_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // command word copy and line state of the predictor
  logic [CMD_LOW_W-1:0]  cmd_low = CMD_LOW_RST;
  logic [CMD_HIGH_W-1:0] cmd_high = CMD_HIGH_RST;
  logic [CMD_LEN_W-1:0]  cmd_len = CMD_LEN_RST;
  int                    ln_len = 0;
  logic                  ln_prefix_ok = 1'b1;
  logic                  ln_invalid = 1'b0;
  logic                  ln_overflow = 1'b0;
  logic                  cr_pending = 1'b0;

  logic [7:0]  rx_bytes[$];
  ucl_result_t pending_results[$];
  logic        in_fire = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          results_seen = 0;
  ucl_result_t got;
  ucl_result_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("uart_command_line_matcher_core_tb: done, errors");
    $finish;
  end

  function automatic logic [7:0] cmd_char(int pos);
    if (pos < 8) return cmd_low[8*pos +: 8];
    if (pos < 10) return cmd_high[8*(pos-8) +: 8];
    return 8'h00;
  endfunction

  function automatic void clear_line();
    ln_len = 0;
    ln_prefix_ok = 1'b1;
    ln_invalid = 1'b0;
    ln_overflow = 1'b0;
    cr_pending = 1'b0;
  endfunction

  function automatic logic line_active();
    return ln_len != 0 || ln_invalid || ln_overflow;
  endfunction

  function automatic ucl_event_t drop_event(logic at_lf);
    if (!line_active()) return EV_NONE;
    if (ln_overflow) return EV_OVERLONG;
    if (ln_invalid) return EV_INVALID;
    return at_lf ? EV_MISMATCH : EV_BARE_CR;
  endfunction

  function automatic ucl_result_t match_byte(logic [7:0] b);
    ucl_result_t r;
    logic ok;
    r = '0;
    r.line_event = EV_NONE;
    if (b == CHAR_LF) begin
      ok = !ln_invalid && !ln_overflow && ln_prefix_ok && cmd_len >= 1 &&
           cmd_len <= CMD_CHARS_MAX && ln_len == int'(cmd_len);
      if (ok) begin
        r.command_accepted = 1'b1;
        r.line_event = EV_ACCEPT;
      end else begin
        r.line_event = drop_event(1'b1);
      end
      clear_line();
    end else if (b == CHAR_CR) begin
      if (cr_pending) begin
        r.line_event = drop_event(1'b0);
        clear_line();
      end
      cr_pending = 1'b1;
    end else begin
      if (cr_pending) begin
        r.line_event = drop_event(1'b0);
        clear_line();
      end
      if (b < PRINT_LO || b > PRINT_HI) begin
        if (!line_active()) r.stray_byte = 1'b1;
        else ln_invalid = 1'b1;
      end else if (!ln_invalid && !ln_overflow) begin
        if (ln_len >= LINE_CAP - 1) begin
          ln_overflow = 1'b1;
        end else begin
          if (ln_len < int'(cmd_len) && ln_len < CMD_CHARS_MAX && b != cmd_char(ln_len))
            ln_prefix_ok = 1'b0;
          ln_len++;
        end
      end
    end
    return r;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // predict on input items, check result items
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) pending_results.push_back(match_byte(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = ucl_result_t'(out_tdata[RESULT_W-1:0]);
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result item %0h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.command_accepted !== want.command_accepted ||
            got.line_event !== want.line_event || got.stray_byte !== want.stray_byte ||
            out_tdata[OUT_W-1:RESULT_W] !== '0)
          note_error($sformatf(
            "item %0d: expected acc=%0b ev=%0d stray=%0b, got acc=%0b ev=%0d stray=%0b pad=%0h",
            results_seen, want.command_accepted, want.line_event, want.stray_byte,
            got.command_accepted, got.line_event, got.stray_byte,
            out_tdata[OUT_W-1:RESULT_W]));
      end
      results_seen++;
    end
  end

  // byte driver and result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_fire) begin
        if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= rx_bytes.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_cmd_reg(logic [CFG_IDX_W-1:0] idx, logic [CMD_LOW_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IDX_CMD_LOW:  cmd_low = val;
      CFG_IDX_CMD_HIGH: cmd_high = val[CMD_HIGH_W-1:0];
      CFG_IDX_CMD_LEN:  cmd_len = val[CMD_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_command(logic [79:0] word, logic [CMD_LEN_W-1:0] len);
    logic [CMD_LOW_W-1:0] data;
    write_cmd_reg(CFG_IDX_CMD_LOW, word[63:0]);
    data = {$urandom(), $urandom()};
    data[15:0] = word[79:64];
    write_cmd_reg(CFG_IDX_CMD_HIGH, data);
    data = {$urandom(), $urandom()};
    data[CMD_LEN_W-1:0] = len;
    write_cmd_reg(CFG_IDX_CMD_LEN, data);
  endtask

  function automatic logic [79:0] random_word();
    logic [79:0] w;
    for (int i = 0; i < 10; i++) w[8*i +: 8] = 8'($urandom_range(PRINT_LO, PRINT_HI));
    return w;
  endfunction

  function automatic logic [7:0] random_ctrl();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  // mostly command lines and near misses, the rest broken lines and noise
  task automatic add_traffic(int n);
    int start;
    int kind;
    int nchar;
    int len;
    int pos;
    logic [7:0] line[$];
    start = rx_bytes.size();
    nchar = (cmd_len > CMD_CHARS_MAX) ? CMD_CHARS_MAX : int'(cmd_len);
    while (rx_bytes.size() - start < n) begin
      kind = $urandom_range(99);
      line.delete();
      if (kind < 60) begin
        for (int i = 0; i < nchar; i++) line.push_back(cmd_char(i));
        if (kind >= 42) begin
          case ($urandom_range(2))
            0: if (nchar > 0)
                 line[$urandom_range(nchar-1)] = 8'($urandom_range(PRINT_LO, PRINT_HI));
            1: if (line.size() > 0) void'(line.pop_back());
            default: line.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
          endcase
        end
        if ($urandom_range(3) == 0) line.push_back(CHAR_CR);
        line.push_back(CHAR_LF);
      end else if (kind < 80) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(29, 40) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++) line.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
        if (kind >= 72) begin
          pos = $urandom_range(len);
          line.insert(pos, random_ctrl());
        end
        line.push_back(CHAR_LF);
      end else if (kind < 90) begin
        len = $urandom_range(nchar);
        for (int i = 0; i < len; i++) line.push_back(cmd_char(i));
        line.push_back(CHAR_CR);
        line.push_back($urandom_range(1) ? CHAR_CR : 8'($urandom_range(255)));
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) line.push_back(8'($urandom_range(255)));
      end
      foreach (line[i]) rx_bytes.push_back(line[i]);
    end
  endtask

  task automatic drain();
    while (rx_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    logic [CMD_LOW_W-1:0] data;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, default command word
    for (int i = 0; i < CMD_CHARS_MAX; i++) rx_bytes.push_back(cmd_char(i));
    rx_bytes.push_back(CHAR_LF);
    rx_bytes.push_back(CHAR_CR);
    rx_bytes.push_back(CHAR_LF);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'h41);
    rx_bytes.push_back(8'h7f);
    rx_bytes.push_back(CHAR_LF);
    rx_bytes.push_back(PRINT_HI);
    rx_bytes.push_back(PRINT_LO);
    rx_bytes.push_back(CHAR_CR);
    rx_bytes.push_back(CHAR_CR);
    rx_bytes.push_back(8'hff);
    rx_bytes.push_back(8'h57);
    rx_bytes.push_back(CHAR_LF);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: load_command(random_word(), 4'd1);
        2: load_command({80{1'b1}}, 4'd15);
        3: begin
          load_command('0, 4'd0);
          data = {$urandom(), $urandom()};
          write_cmd_reg(CFG_IDX_SPARE, data);
        end
        4: load_command(random_word(), 4'd10);
        5: load_command(random_word(), 4'($urandom_range(2, 9)));
        6: load_command(random_word(), 4'($urandom_range(1, 10)));
        7: load_command({CMD_HIGH_RST, CMD_LOW_RST}, CMD_LEN_RST);
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      add_traffic(40);
      drain();
      add_traffic(40);
      drain();
    end

    if (pending_results.size() != 0)
      note_error($sformatf("%0d result items never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("uart_command_line_matcher_core_tb: done, clean");
    end else begin
      $display("uart_command_line_matcher_core_tb: done, errors");
    end
    $finish;
  end

endmodule
